// File: hdl/dgpt_pkg.sv
// ----------------------------------------------------------------------------
// Decaying goal point table: shared package
// Field widths, operation and status codes, register map and the structs
// that travel between the table's modules.
// ----------------------------------------------------------------------------
package dgpt_pkg;

   // Widths of the payload fields and of the control registers.
   localparam int unsigned FIELD_W = 16;
   localparam int unsigned RAD_W   = 15;
   localparam int unsigned DEC_W   = 16;
   localparam int unsigned THR_W   = 15;
   localparam int unsigned STAT_W  = 3;
   localparam int unsigned COUNT_W = 7;
   localparam int unsigned R2_W    = 2 * RAD_W;
   localparam int unsigned PROD_W  = 2 * FIELD_W;

   // Register port geometry: three 32-bit registers at byte offsets 0, 4, 8.
   localparam int unsigned PADDR_W = 4;
   localparam int unsigned PDATA_W = 32;

   // Register indexes, taken from paddr[3:2].
   localparam logic [1:0] REG_RADIUS = 2'd0;
   localparam logic [1:0] REG_DECAY  = 2'd1;
   localparam logic [1:0] REG_THRESH = 2'd2;

   // Reset values of the registers.
   localparam logic [RAD_W-1:0] RADIUS_RST = 15'd64;
   localparam logic [DEC_W-1:0] DECAY_RST  = 16'd64881;
   localparam logic [THR_W-1:0] THRESH_RST = 15'd51;

   typedef enum logic {
      OP_ADD  = 1'b0,
      OP_TICK = 1'b1
   } op_type;

   typedef enum logic [STAT_W-1:0] {
      ST_ADDED = 3'd0,
      ST_DUP   = 3'd1,
      ST_FULL  = 3'd2,
      ST_BEST  = 3'd3,
      ST_EMPTY = 3'd4
   } status_type;

   // One table slot as it lies in the memory.
   typedef struct packed {
      logic                      valid;
      logic signed [FIELD_W-1:0] x;
      logic signed [FIELD_W-1:0] y;
      logic signed [FIELD_W-1:0] v;
   } entry_type;

   // Current register values.
   typedef struct packed {
      logic [RAD_W-1:0] radius;
      logic [DEC_W-1:0] decay;
      logic [THR_W-1:0] thresh;
   } csr_type;

   // Status of the scan pipeline, seen by the controller.
   typedef struct packed {
      logic busy;
      logic dup;
      logic free_found;
      logic best_found;
      logic drop;
   } scan_stat_type;

endpackage

// File: hdl/dgpt_mem.sv
// ----------------------------------------------------------------------------
// Decaying goal point table: entry memory
// One write port and one read port; read data is registered, so it appears
// in the cycle after the address.
// ----------------------------------------------------------------------------
module dgpt_mem #(
   parameter int unsigned DEPTH  = 64,
   parameter int unsigned ADDR_W = 6
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [ADDR_W-1:0]   wr_addr,
   input  dgpt_pkg::entry_type wr_data,
   input  logic                rd_en,
   input  logic [ADDR_W-1:0]   rd_addr,
   output dgpt_pkg::entry_type rd_data
);
   import dgpt_pkg::*;

   entry_type entry_mem_ff [DEPTH];
   entry_type rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= entry_mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/dgpt_csr.sv
// ----------------------------------------------------------------------------
// Decaying goal point table: control registers
// Dedupe radius, decay factor and drop threshold behind a simple register
// port with a setup and an access cycle and no wait states.
// ----------------------------------------------------------------------------
module dgpt_csr (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [dgpt_pkg::PADDR_W-1:0] paddr,
   input  logic [dgpt_pkg::PDATA_W-1:0] pwdata,
   output logic [dgpt_pkg::PDATA_W-1:0] prdata,
   output logic                         pready,
   output dgpt_pkg::csr_type            csr
);
   import dgpt_pkg::*;

   logic [RAD_W-1:0] radius_ff;
   logic [DEC_W-1:0] decay_ff;
   logic [THR_W-1:0] thresh_ff;
   logic             wr_fire;
   logic [1:0]       reg_idx;

   assign pready  = 1'b1;
   assign wr_fire = psel && penable && pwrite;
   assign reg_idx = paddr[3:2];

   // Register writes in the access cycle.
   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= RADIUS_RST;
         decay_ff  <= DECAY_RST;
         thresh_ff <= THRESH_RST;
      end else if (wr_fire) begin
         case (reg_idx)
            REG_RADIUS: radius_ff <= pwdata[RAD_W-1:0];
            REG_DECAY:  decay_ff  <= pwdata[DEC_W-1:0];
            REG_THRESH: thresh_ff <= pwdata[THR_W-1:0];
            default: ;
         endcase
      end
   end

   // Read data, zero extended.
   always_comb begin
      case (reg_idx)
         REG_RADIUS: prdata = {{(PDATA_W-RAD_W){1'b0}}, radius_ff};
         REG_DECAY:  prdata = {{(PDATA_W-DEC_W){1'b0}}, decay_ff};
         REG_THRESH: prdata = {{(PDATA_W-THR_W){1'b0}}, thresh_ff};
         default:    prdata = '0;
      endcase
   end

   assign csr.radius = radius_ff;
   assign csr.decay  = decay_ff;
   assign csr.thresh = thresh_ff;

endmodule

// File: hdl/dgpt_pipe.sv
// ----------------------------------------------------------------------------
// Decaying goal point table: scan pipeline
// Takes one memory entry per cycle. Add items measure squared distance to
// the new point and track the first free slot; tick items track the best
// value and write back each decayed value, freeing entries that fall low.
// ----------------------------------------------------------------------------
module dgpt_pipe #(
   parameter int unsigned ADDR_W = 6
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  dgpt_pkg::op_type                    op,
   input  logic signed [dgpt_pkg::FIELD_W-1:0] point_x,
   input  logic signed [dgpt_pkg::FIELD_W-1:0] point_y,
   input  logic [dgpt_pkg::R2_W-1:0]           radius_sq,
   input  dgpt_pkg::csr_type                   csr,
   input  logic                                rd_en,
   input  logic [ADDR_W-1:0]                   rd_addr,
   input  dgpt_pkg::entry_type                 rd_data,
   output logic                                wr_en,
   output logic [ADDR_W-1:0]                   wr_addr,
   output dgpt_pkg::entry_type                 wr_data,
   output dgpt_pkg::scan_stat_type             stat,
   output logic [ADDR_W-1:0]                   free_idx,
   output logic signed [dgpt_pkg::FIELD_W-1:0] best_x,
   output logic signed [dgpt_pkg::FIELD_W-1:0] best_y,
   output logic signed [dgpt_pkg::FIELD_W-1:0] best_v
);
   import dgpt_pkg::*;

   // Read stage: tracks which read is in the memory's output register.
   logic              s0_vld_ff;
   logic [ADDR_W-1:0] s0_idx_ff;

   // Stage 1: operands of the multipliers.
   logic               s1_vld_ff;
   logic [ADDR_W-1:0]  s1_idx_ff;
   entry_type          s1_ent_ff;
   logic [FIELD_W-1:0] s1_da_ff;
   logic [FIELD_W-1:0] s1_db_ff;
   logic [FIELD_W-1:0] s1_da_in;
   logic [FIELD_W-1:0] s1_db_in;

   // Stage 2: products.
   logic               s2_vld_ff;
   logic [ADDR_W-1:0]  s2_idx_ff;
   entry_type          s2_ent_ff;
   logic [PROD_W-1:0]  s2_p0_ff;
   logic [PROD_W-1:0]  s2_p1_ff;

   // Trackers over the whole walk.
   logic                      dup_ff;
   logic                      free_found_ff;
   logic [ADDR_W-1:0]         free_idx_ff;
   logic                      best_found_ff;
   logic signed [FIELD_W-1:0] best_x_ff;
   logic signed [FIELD_W-1:0] best_y_ff;
   logic signed [FIELD_W-1:0] best_v_ff;

   logic signed [FIELD_W:0] diff_x;
   logic signed [FIELD_W:0] diff_y;
   logic signed [FIELD_W:0] val_ext;
   logic [FIELD_W:0]        mag_x;
   logic [FIELD_W:0]        mag_y;
   logic [FIELD_W:0]        mag_v;
   logic [PROD_W:0]         dist_sq;
   logic                    near;
   logic [FIELD_W-1:0]      dec_mag;
   logic                    drop;
   logic                    take_free;
   logic                    take_best;

   // Stage 1 operands: distance components for an add, magnitude and
   // decay factor for a tick.
   always_comb begin
      diff_x  = {rd_data.x[FIELD_W-1], rd_data.x} - {point_x[FIELD_W-1], point_x};
      diff_y  = {rd_data.y[FIELD_W-1], rd_data.y} - {point_y[FIELD_W-1], point_y};
      val_ext = {rd_data.v[FIELD_W-1], rd_data.v};
      mag_x   = diff_x[FIELD_W] ? 17'(-diff_x) : 17'(diff_x);
      mag_y   = diff_y[FIELD_W] ? 17'(-diff_y) : 17'(diff_y);
      mag_v   = val_ext[FIELD_W] ? 17'(-val_ext) : 17'(val_ext);
      if (op == OP_ADD) begin
         s1_da_in = mag_x[FIELD_W-1:0];
         s1_db_in = mag_y[FIELD_W-1:0];
      end else begin
         s1_da_in = mag_v[FIELD_W-1:0];
         s1_db_in = csr.decay;
      end
   end

   // Valid bits of the pipeline stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         s0_vld_ff <= 1'b0;
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
      end else begin
         s0_vld_ff <= rd_en;
         s1_vld_ff <= s0_vld_ff;
         s2_vld_ff <= s1_vld_ff;
      end
   end

   // Stage payloads; the add uses both squares, the tick only the first product.
   always_ff @(posedge clock) begin
      s0_idx_ff <= rd_addr;
      s1_idx_ff <= s0_idx_ff;
      s1_ent_ff <= rd_data;
      s1_da_ff  <= s1_da_in;
      s1_db_ff  <= s1_db_in;
      s2_idx_ff <= s1_idx_ff;
      s2_ent_ff <= s1_ent_ff;
      s2_p0_ff  <= s1_da_ff * ((op == OP_ADD) ? s1_da_ff : s1_db_ff);
      s2_p1_ff  <= s1_db_ff * s1_db_ff;
   end

   // Stage 3: duplicate compare and decay write-back.
   always_comb begin
      dist_sq = {1'b0, s2_p0_ff} + {1'b0, s2_p1_ff};
      near    = dist_sq < {{(PROD_W+1-R2_W){1'b0}}, radius_sq};
      dec_mag = s2_p0_ff[PROD_W-1:FIELD_W];
      drop    = dec_mag < {1'b0, csr.thresh};
      wr_en   = s2_vld_ff && s2_ent_ff.valid && (op == OP_TICK);
      wr_addr = s2_idx_ff;
      wr_data.valid = !drop;
      wr_data.x     = s2_ent_ff.x;
      wr_data.y     = s2_ent_ff.y;
      wr_data.v     = s2_ent_ff.v[FIELD_W-1] ? -dec_mag : dec_mag;
   end

   // Lowest free slot, and best value with the lowest slot kept on ties.
   assign take_free = s0_vld_ff && !rd_data.valid && !free_found_ff;
   assign take_best = s0_vld_ff && rd_data.valid &&
                      (!best_found_ff || (rd_data.v > best_v_ff));

   always_ff @(posedge clock) begin
      if (reset || start) begin
         dup_ff        <= 1'b0;
         free_found_ff <= 1'b0;
         best_found_ff <= 1'b0;
      end else begin
         if (s2_vld_ff && s2_ent_ff.valid && (op == OP_ADD) && near) begin
            dup_ff <= 1'b1;
         end
         if (take_free) begin
            free_found_ff <= 1'b1;
         end
         if (take_best) begin
            best_found_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take_free) begin
         free_idx_ff <= s0_idx_ff;
      end
      if (take_best) begin
         best_x_ff <= rd_data.x;
         best_y_ff <= rd_data.y;
         best_v_ff <= rd_data.v;
      end
   end

   assign stat.busy       = s0_vld_ff || s1_vld_ff || s2_vld_ff;
   assign stat.dup        = dup_ff;
   assign stat.free_found = free_found_ff;
   assign stat.best_found = best_found_ff;
   assign stat.drop       = wr_en && drop;
   assign free_idx        = free_idx_ff;
   assign best_x          = best_x_ff;
   assign best_y          = best_y_ff;
   assign best_v          = best_v_ff;

endmodule

// File: hdl/decaying_goal_point_table.sv
// ----------------------------------------------------------------------------
// Decaying goal point table
// Holds up to CAPACITY valued goal points in one memory. Adds are rejected
// when full or near a stored point; ticks report the best point, then decay
// every value and free entries that drop under the threshold.
// ----------------------------------------------------------------------------
//
//   Port group   Direction  Handshake            Contents
//   req_*        in         req_valid/req_ready  operation, point x/y/value
//   rsp_*        out        rsp_valid/rsp_ready  status, best x/y/value, count
//   p*           in/out     psel/penable/pready  radius, decay, threshold
//
// An add or a tick walks the whole memory, one entry a cycle through a read
// stage and two pipeline stages; the sequencer then waits in S_DRAIN until
// the pipeline is empty, and in S_DONE loads the output register once that
// is free, which raises rsp_valid. The next beat is taken only back in S_IDLE,
// after that load. An add to a full table skips the walk and goes straight
// to S_DONE. After reset a clearing pass marks every slot free; req_ready
// stays low meanwhile. A new beat is taken once the previous result sits in
// the output register, even if rsp_ready is low.
//
module decaying_goal_point_table #(
   parameter int unsigned CAPACITY = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   // Input channel.
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_operation,
   input  logic signed [dgpt_pkg::FIELD_W-1:0] req_point_x,
   input  logic signed [dgpt_pkg::FIELD_W-1:0] req_point_y,
   input  logic signed [dgpt_pkg::FIELD_W-1:0] req_point_value,
   // Result channel.
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [dgpt_pkg::STAT_W-1:0]         rsp_status,
   output logic signed [dgpt_pkg::FIELD_W-1:0] rsp_best_x,
   output logic signed [dgpt_pkg::FIELD_W-1:0] rsp_best_y,
   output logic signed [dgpt_pkg::FIELD_W-1:0] rsp_best_value,
   output logic [dgpt_pkg::COUNT_W-1:0]        rsp_entry_count,
   // Register port.
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [dgpt_pkg::PADDR_W-1:0]        paddr,
   input  logic [dgpt_pkg::PDATA_W-1:0]        pwdata,
   output logic [dgpt_pkg::PDATA_W-1:0]        prdata,
   output logic                                pready
);
   import dgpt_pkg::*;

   localparam int unsigned ADDR_W = $clog2(CAPACITY);
   localparam int unsigned CNT_W  = $clog2(CAPACITY + 1);
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(CAPACITY - 1);
   localparam logic [CNT_W-1:0]  FULL_CNT  = CNT_W'(CAPACITY);

   typedef enum logic [4:0] {
      S_CLEAR = 5'b00001,
      S_IDLE  = 5'b00010,
      S_SCAN  = 5'b00100,
      S_DRAIN = 5'b01000,
      S_DONE  = 5'b10000
   } state_type;

   state_type                 state_ff, state_in;
   logic [ADDR_W-1:0]         addr_ff, addr_in;
   logic [CNT_W-1:0]          count_ff, count_in;
   op_type                    op_ff;
   logic signed [FIELD_W-1:0] px_ff, py_ff, pv_ff;
   logic [R2_W-1:0]           r2_ff;
   logic                      full_ff;

   logic                      rsp_valid_ff;
   status_type                rsp_status_ff, rsp_status_in;
   logic signed [FIELD_W-1:0] rsp_x_ff, rsp_y_ff, rsp_v_ff;
   logic [COUNT_W-1:0]        rsp_count_ff;

   csr_type                   csr;
   scan_stat_type             stat;
   entry_type                 rd_data;
   entry_type                 mem_wr_data;
   entry_type                 pipe_wr_data;
   logic [ADDR_W-1:0]         mem_wr_addr, pipe_wr_addr;
   logic                      mem_wr_en, pipe_wr_en;
   logic [ADDR_W-1:0]         free_idx;
   logic signed [FIELD_W-1:0] best_x, best_y, best_v;
   logic                      req_fire;
   logic                      rd_en;
   logic                      clr_wr;
   logic                      ins_wr;
   logic                      rsp_load;
   logic [CNT_W+COUNT_W-1:0]  count_ext;

   // Register file.
   dgpt_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .csr     (csr)
   );

   // Entry memory.
   dgpt_mem #(
      .DEPTH  (CAPACITY),
      .ADDR_W (ADDR_W)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (rd_en),
      .rd_addr (addr_ff),
      .rd_data (rd_data)
   );

   // Scan pipeline.
   dgpt_pipe #(
      .ADDR_W (ADDR_W)
   ) u_pipe (
      .clock     (clock),
      .reset     (reset),
      .start     (req_fire),
      .op        (op_ff),
      .point_x   (px_ff),
      .point_y   (py_ff),
      .radius_sq (r2_ff),
      .csr       (csr),
      .rd_en     (rd_en),
      .rd_addr   (addr_ff),
      .rd_data   (rd_data),
      .wr_en     (pipe_wr_en),
      .wr_addr   (pipe_wr_addr),
      .wr_data   (pipe_wr_data),
      .stat      (stat),
      .free_idx  (free_idx),
      .best_x    (best_x),
      .best_y    (best_y),
      .best_v    (best_v)
   );

   // Handshake and memory control.
   assign req_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign rd_en     = (state_ff == S_SCAN);
   assign clr_wr    = (state_ff == S_CLEAR);
   assign rsp_load  = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_ready);
   assign ins_wr    = rsp_load && (op_ff == OP_ADD) && !full_ff && !stat.dup &&
                      stat.free_found;

   // Write port: clearing pass, insert of a new point, or decay write-back.
   always_comb begin
      if (clr_wr) begin
         mem_wr_en   = 1'b1;
         mem_wr_addr = addr_ff;
         mem_wr_data = '0;
      end else if (ins_wr) begin
         mem_wr_en         = 1'b1;
         mem_wr_addr       = free_idx;
         mem_wr_data.valid = 1'b1;
         mem_wr_data.x     = px_ff;
         mem_wr_data.y     = py_ff;
         mem_wr_data.v     = pv_ff;
      end else begin
         mem_wr_en   = pipe_wr_en;
         mem_wr_addr = pipe_wr_addr;
         mem_wr_data = pipe_wr_data;
      end
   end

   // Entry count: up on an insert, down on each freed entry.
   always_comb begin
      count_in = count_ff;
      if (ins_wr) begin
         count_in = count_ff + 1'b1;
      end else if (stat.drop) begin
         count_in = count_ff - 1'b1;
      end
   end

   // Result status.
   always_comb begin
      if (op_ff == OP_TICK) begin
         rsp_status_in = stat.best_found ? ST_BEST : ST_EMPTY;
      end else if (full_ff || (!stat.dup && !stat.free_found)) begin
         rsp_status_in = ST_FULL;
      end else if (stat.dup) begin
         rsp_status_in = ST_DUP;
      end else begin
         rsp_status_in = ST_ADDED;
      end
   end

   // Sequencer.
   always_comb begin
      state_in = state_ff;
      addr_in  = addr_ff;
      case (state_ff)
         S_CLEAR: begin
            addr_in = addr_ff + 1'b1;
            if (addr_ff == LAST_ADDR) begin
               addr_in  = '0;
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_fire) begin
               if ((req_operation == OP_ADD) && (count_ff >= FULL_CNT)) begin
                  state_in = S_DONE;
               end else begin
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            addr_in = addr_ff + 1'b1;
            if (addr_ff == LAST_ADDR) begin
               addr_in  = '0;
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            if (!stat.busy) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (rsp_load) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
            addr_in  = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         addr_ff  <= '0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         addr_ff  <= addr_in;
         count_ff <= count_in;
      end
   end

   // Item registers, loaded with the accepted beat.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         op_ff   <= op_type'(req_operation);
         px_ff   <= req_point_x;
         py_ff   <= req_point_y;
         pv_ff   <= req_point_value;
         r2_ff   <= csr.radius * csr.radius;
         full_ff <= (req_operation == OP_ADD) && (count_ff >= FULL_CNT);
      end
   end

   // Output register.
   assign count_ext = {{COUNT_W{1'b0}}, count_in};

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_status_ff <= rsp_status_in;
         rsp_count_ff  <= count_ext[COUNT_W-1:0];
         if (rsp_status_in == ST_BEST) begin
            rsp_x_ff <= best_x;
            rsp_y_ff <= best_y;
            rsp_v_ff <= best_v;
         end else begin
            rsp_x_ff <= '0;
            rsp_y_ff <= '0;
            rsp_v_ff <= '0;
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_best_x      = rsp_x_ff;
   assign rsp_best_y      = rsp_y_ff;
   assign rsp_best_value  = rsp_v_ff;
   assign rsp_entry_count = rsp_count_ff;

   // The count never passes the table size.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_CNT)
      else $error("entry count above capacity");

   // Only one source drives the memory write port in a cycle.
   a_one_writer: assert property (@(posedge clock) disable iff (reset)
      $onehot0({clr_wr, ins_wr, pipe_wr_en}))
      else $error("memory write port contention");

   // A new beat is taken only with the scan pipeline empty.
   a_ready_idle_pipe: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !stat.busy)
      else $error("beat accepted while the pipeline is busy");

   // The count holds while the table waits for a beat.
   a_count_stable: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |=> (count_ff == $past(count_ff)))
      else $error("entry count changed while idle");

endmodule
